// ===== hw/rtl/smsl_pkg.sv =====
// shared constants and types for the stereo mean-square level meter
package smsl_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int LEVEL_W         = 31;
  localparam int FRAME_SUM_W     = 40;
  localparam int ROUND_SUM_W     = 35;
  localparam int PAIR_CNT_W      = 9;
  localparam int ROUND_CNT_W     = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 31;
  localparam int DIV_W           = FRAME_SUM_W;
  localparam int DVSR_W          = PAIR_CNT_W;
  localparam int DIV_CNT_W       = $clog2(DIV_W + 1);

  localparam logic [PAIR_CNT_W-1:0]  MAX_FRAME_PAIRS = PAIR_CNT_W'(320);
  localparam logic [ROUND_CNT_W-1:0] ROUNDS_RESET    = ROUND_CNT_W'(10);
  localparam logic [LEVEL_W-1:0]     THRESHOLD_RESET = LEVEL_W'(500);

  localparam logic [CFG_IDX_W-1:0] REG_MIC_READY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  localparam logic OP_PAIR        = 1'b0;
  localparam logic OP_EMPTY_FRAME = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/stereo_mean_square_level_meter.sv =====
// Stereo mean-square level meter: a sample pair is accepted, then each channel is squared in
// turn through one shared 16x16 squarer and accumulated. The pair that closes a frame adds a
// close step, two serial divisions by the frame's pair count on the shared one-bit-per-cycle
// divider, and a check step. A frame that completes a valid measurement adds two more
// divisions by the target, and any completed measurement adds an emit step that loads the
// result into the output register. An empty-frame request goes from accept to the check step,
// plus the same measurement steps when it completes one. Pairs that arrive at a full frame are
// taken and dropped; one marked last still closes the frame. The input side is ready only
// while the sequencer is idle; a finished result waits in the output register while further
// requests are taken, and the sequencer holds a new result until that register is free.
module stereo_mean_square_level_meter
  import smsl_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic signed [SAMPLE_W-1:0]   left_sample,
  input  logic signed [SAMPLE_W-1:0]   right_sample,
  input  logic                         frame_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         valid_res,
  output logic        [LEVEL_W-1:0]    level_left,
  output logic        [LEVEL_W-1:0]    level_right,
  output logic        [LEVEL_W-1:0]    level_mono,
  output logic                         left_loud,
  output logic                         right_loud
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SQ_L  = 11'b000_0000_0010,
    S_SQ_R  = 11'b000_0000_0100,
    S_ACC_R = 11'b000_0000_1000,
    S_CLOSE = 11'b000_0001_0000,
    S_DIV_L = 11'b000_0010_0000,
    S_DIV_R = 11'b000_0100_0000,
    S_CHECK = 11'b000_1000_0000,
    S_AVG_L = 11'b001_0000_0000,
    S_AVG_R = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic                   mic_ready;
  logic [ROUND_CNT_W-1:0] round_target;
  logic [LEVEL_W-1:0]     threshold;

  logic signed [SAMPLE_W-1:0] left_q;
  logic signed [SAMPLE_W-1:0] right_q;
  logic                       last_q;

  logic [FRAME_SUM_W-1:0] square_sum_left;
  logic [FRAME_SUM_W-1:0] square_sum_right;
  logic [PAIR_CNT_W-1:0]  pairs_in_frame;
  logic [ROUND_SUM_W-1:0] round_sum_left;
  logic [ROUND_SUM_W-1:0] round_sum_right;
  logic [ROUND_CNT_W-1:0] rounds_done;
  logic                   any_pairs_seen;
  logic                   div_issued;
  logic                   meas_ok;
  logic [LEVEL_W-1:0]     lvl_l;
  logic [LEVEL_W-1:0]     lvl_r;

  logic signed [SAMPLE_W-1:0] sq_in;
  logic [LEVEL_W-1:0]         sq_out;
  logic [ROUND_CNT_W-1:0]     target;
  logic [LEVEL_W:0]           mono_sum;
  logic                       out_free;
  logic                       div_state;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  assign in_ready  = (state == S_IDLE);
  assign target    = (round_target == '0) ? ROUND_CNT_W'(1) : round_target;
  assign mono_sum  = {1'b0, lvl_l} + {1'b0, lvl_r};
  assign out_free  = !out_valid || out_ready;
  assign div_state = (state == S_DIV_L) || (state == S_DIV_R) ||
                     (state == S_AVG_L) || (state == S_AVG_R);

  assign sq_in = (state == S_SQ_L) ? left_q : right_q;

  smsl_squarer u_squarer (
    .clk    (clk),
    .sample (sq_in),
    .square (sq_out)
  );

  always_comb begin
    div_req.start = div_state && !div_issued;
    unique case (state)
      S_DIV_L: begin
        div_req.dividend = square_sum_left;
        div_req.divisor  = pairs_in_frame;
      end
      S_DIV_R: begin
        div_req.dividend = square_sum_right;
        div_req.divisor  = pairs_in_frame;
      end
      S_AVG_L: begin
        div_req.dividend = DIV_W'(round_sum_left);
        div_req.divisor  = DVSR_W'(target);
      end
      default: begin
        div_req.dividend = DIV_W'(round_sum_right);
        div_req.divisor  = DVSR_W'(target);
      end
    endcase
  end

  smsl_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mic_ready    <= 1'b0;
      round_target <= ROUNDS_RESET;
      threshold    <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIC_READY:    mic_ready    <= cfg_data[0];
        REG_ROUND_TARGET: round_target <= cfg_data[ROUND_CNT_W-1:0];
        REG_THRESHOLD:    threshold    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      left_q  <= left_sample;
      right_q <= right_sample;
      last_q  <= frame_last;
    end
  end

  // sequencer and measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      square_sum_left  <= '0;
      square_sum_right <= '0;
      pairs_in_frame   <= '0;
      round_sum_left   <= '0;
      round_sum_right  <= '0;
      rounds_done      <= '0;
      any_pairs_seen   <= 1'b0;
      div_issued       <= 1'b0;
      meas_ok          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // a result loaded in this cycle keeps the output valid
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      if (div_req.start) begin
        div_issued <= 1'b1;
      end
      if (div_rsp.done) begin
        div_issued <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (opcode == OP_EMPTY_FRAME) begin
              // drops any partial frame, counts as a round that adds nothing
              square_sum_left  <= '0;
              square_sum_right <= '0;
              pairs_in_frame   <= '0;
              rounds_done      <= rounds_done + ROUND_CNT_W'(1);
              state            <= S_CHECK;
            end else if (pairs_in_frame < MAX_FRAME_PAIRS) begin
              state <= S_SQ_L;
            end else if (frame_last) begin
              state <= S_CLOSE;
            end
          end
        end
        S_SQ_L: begin
          state <= S_SQ_R;
        end
        S_SQ_R: begin
          square_sum_left <= square_sum_left + FRAME_SUM_W'(sq_out);
          state           <= S_ACC_R;
        end
        S_ACC_R: begin
          square_sum_right <= square_sum_right + FRAME_SUM_W'(sq_out);
          pairs_in_frame   <= pairs_in_frame + PAIR_CNT_W'(1);
          state            <= last_q ? S_CLOSE : S_IDLE;
        end
        S_CLOSE: begin
          if (pairs_in_frame != '0) begin
            state <= S_DIV_L;
          end else begin
            rounds_done <= rounds_done + ROUND_CNT_W'(1);
            state       <= S_CHECK;
          end
        end
        S_DIV_L: begin
          if (div_rsp.done) begin
            round_sum_left <= round_sum_left + div_rsp.quotient[ROUND_SUM_W-1:0];
            state          <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_rsp.done) begin
            round_sum_right  <= round_sum_right + div_rsp.quotient[ROUND_SUM_W-1:0];
            any_pairs_seen   <= 1'b1;
            rounds_done      <= rounds_done + ROUND_CNT_W'(1);
            square_sum_left  <= '0;
            square_sum_right <= '0;
            pairs_in_frame   <= '0;
            state            <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rounds_done < target) begin
            state <= S_IDLE;
          end else if (mic_ready && any_pairs_seen) begin
            meas_ok <= 1'b1;
            state   <= S_AVG_L;
          end else begin
            meas_ok <= 1'b0;
            state   <= S_EMIT;
          end
        end
        S_AVG_L: begin
          if (div_rsp.done) begin
            state <= S_AVG_R;
          end
        end
        S_AVG_R: begin
          if (div_rsp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            round_sum_left  <= '0;
            round_sum_right <= '0;
            rounds_done     <= '0;
            any_pairs_seen  <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // averaged levels, zero for an invalid measurement
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      lvl_l <= '0;
      lvl_r <= '0;
    end else if (state == S_AVG_L && div_rsp.done) begin
      lvl_l <= div_rsp.quotient[LEVEL_W-1:0];
    end else if (state == S_AVG_R && div_rsp.done) begin
      lvl_r <= div_rsp.quotient[LEVEL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      valid_res   <= meas_ok;
      level_left  <= lvl_l;
      level_right <= lvl_r;
      level_mono  <= mono_sum[LEVEL_W:1];
      left_loud   <= meas_ok && (lvl_l > threshold);
      right_loud  <= meas_ok && (lvl_r > threshold);
    end
  end

  // a pair that lands on a full frame without closing it is dropped in place
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (opcode == OP_EMPTY_FRAME || pairs_in_frame < MAX_FRAME_PAIRS || frame_last)
    |=> state != S_IDLE)
    else $error("accepted request did not start the sequencer");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> level_left == '0 && level_right == '0 &&
                                !left_loud && !right_loud)
    else $error("invalid result carries nonzero levels");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> div_state && div_issued)
    else $error("divider finished outside a division step");

  a_pairs_bounded: assert property (@(posedge clk) disable iff (rst)
    pairs_in_frame <= MAX_FRAME_PAIRS)
    else $error("frame pair count beyond capacity");

endmodule

// ===== hw/rtl/smsl_squarer.sv =====
// registered 16-bit signed squarer shared by both channels
module smsl_squarer
  import smsl_pkg::*;
(
  input  logic                       clk,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic        [LEVEL_W-1:0]  square
);

  logic [SAMPLE_W-1:0]   mag;
  logic [2*SAMPLE_W-1:0] prod;

  // magnitude of the most negative code is 2^15, still fits unsigned
  assign mag  = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
  assign prod = mag * mag;

  always_ff @(posedge clk) begin
    square <= prod[LEVEL_W-1:0];
  end

endmodule

// ===== hw/rtl/smsl_divider.sv =====
// restoring divider, one quotient bit per cycle
module smsl_divider
  import smsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]     work;
  logic [DVSR_W-1:0]    dvsr;
  logic [DVSR_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;
  logic                 done;
  logic [DVSR_W:0]      trial;
  logic                 fits;

  assign trial = {rem, work[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      work <= req.dividend;
      dvsr <= req.divisor;
      rem  <= '0;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits back in DVSR_W bits
      rem  <= fits ? DVSR_W'(trial - {1'b0, dvsr}) : trial[DVSR_W-1:0];
      work <= {work[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = work;

endmodule
